### design/playfair_digraph_decrypt_core_defines.svh
// assertion macros for the playfair digraph decrypt core checker
// no dependencies; included by the checker file
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pdd checker: same-cycle property failed");

// next-cycle implication, checked outside reset
`define PDD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pdd checker: next-cycle property failed");

`endif

### design/pdd_pkg.sv
// shared types, constants and helper functions for the playfair decrypt core
// no dependencies
`default_nettype none
package pdd_pkg;

    localparam int KEY_REGS = 4;
    localparam int KEY_W = 56;
    localparam int KEY_BYTES_PER_REG = 7;
    localparam int KEY_LEN_W = 5;
    localparam int LETTERS = 26;
    localparam int CELLS = 25;

    localparam logic [2:0] REG_KEY_CHARS_0 = 3'd0;
    localparam logic [2:0] REG_KEY_CHARS_1 = 3'd1;
    localparam logic [2:0] REG_KEY_CHARS_2 = 3'd2;
    localparam logic [2:0] REG_KEY_CHARS_3 = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_W-1:0] KEY0_RESET = 56'd20340218885197645;
    localparam logic [KEY_W-1:0] KEY1_RESET = 56'd89;
    localparam logic [KEY_W-1:0] KEY2_RESET = 56'd0;
    localparam logic [KEY_W-1:0] KEY3_RESET = 56'd0;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd8;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_LAST = 5'd25;
    localparam logic [4:0] CELL_COUNT = 5'd25;
    localparam logic [2:0] SIDE_LAST = 3'd4;
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_Z = 8'h5a;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7a;
    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam logic [LETTERS-1:0] USED_INIT = 26'd1 << LETTER_J;

    typedef logic [KEY_REGS-1:0][KEY_W-1:0] key_regs_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } letter_t;

    // one write into both square memories
    typedef struct packed {
        logic       we;
        logic [4:0] cell_idx;
        logic [4:0] letter;
        logic [5:0] pos;
    } sq_wr_t;

    // key byte to letter index: case folded, j read as i
    function automatic letter_t key_letter(input logic [7:0] b);
        logic [7:0] u;
        letter_t r;
        u = b;
        if (b >= ASCII_LA && b <= ASCII_LZ) begin
            u = b - CASE_GAP;
        end
        r.ok = (u >= ASCII_A) && (u <= ASCII_Z);
        r.idx = 5'(u - ASCII_A);
        if (r.idx == LETTER_J) begin
            r.idx = LETTER_I;
        end
        return r;
    endfunction

    // ciphertext byte to letter index: uppercase only, j read as i
    function automatic letter_t cipher_letter(input logic [7:0] b);
        letter_t r;
        r.ok = (b >= ASCII_A) && (b <= ASCII_Z);
        r.idx = r.ok ? 5'(b - ASCII_A) : 5'd0;
        if (r.idx == LETTER_J) begin
            r.idx = LETTER_I;
        end
        return r;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        logic [5:0] t;
        t = {1'b0, row, 2'b00} + {3'b000, row} + {3'b000, col};
        return t[4:0];
    endfunction

    // one step back around the 5-wide ring
    function automatic logic [2:0] ring_prev(input logic [2:0] v);
        return (v == 3'd0) ? SIDE_LAST : 3'(v - 3'd1);
    endfunction

endpackage
`default_nettype wire

### design/playfair_digraph_decrypt_core.sv
// Playfair digraph decryptor: one ciphertext letter pair per beat, registered
// through position read, square read and output, one beat per cycle unless a low
// m_ready or a square rebuild stalls it, set by two memories each read at two
// addresses per cycle (letter position, then key square). After reset and after any key
// register write the square is rebuilt, s_ready low, before the next input beat.
// Inputs outside 'A'-'Z' give invalid_letter and zero letters; J is read as I.
// depends on pdd_pkg and pdd_square_build
`default_nettype none
module playfair_digraph_decrypt_core #(
    parameter int MAX_KEY_BYTES = 28
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [pdd_pkg::KEY_W-1:0] cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_cipher_first,
    input  wire logic [7:0]                s_cipher_second,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [6:0]                     m_plain_first,
    output logic [6:0]                     m_plain_second,
    output logic                           m_invalid_letter
);
    import pdd_pkg::*;

    key_regs_t key_regs_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic cfg_clear;
    sq_wr_t sq_wr;
    logic square_ready;

    logic [4:0] sq_mem [CELLS];
    logic [5:0] pos_mem [LETTERS];

    logic en, accept, start_ok;
    letter_t la, lb;
    logic v1_reg, v2_reg, m_valid_reg;
    logic inv1_reg, inv2_reg;
    logic [5:0] pos_a_reg, pos_b_reg;
    logic [4:0] sq_a_reg, sq_b_reg;
    logic [6:0] plain_first_reg, plain_second_reg;
    logic invalid_reg;
    logic [2:0] r1, c1, r2, c2;
    logic [4:0] cell_a, cell_b;

    assign cfg_clear = cfg_we && (cfg_index <= REG_KEY_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_regs_reg[0] <= KEY0_RESET;
            key_regs_reg[1] <= KEY1_RESET;
            key_regs_reg[2] <= KEY2_RESET;
            key_regs_reg[3] <= KEY3_RESET;
            key_length_reg <= KEY_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_CHARS_0: key_regs_reg[0] <= cfg_wdata;
                REG_KEY_CHARS_1: key_regs_reg[1] <= cfg_wdata;
                REG_KEY_CHARS_2: key_regs_reg[2] <= cfg_wdata;
                REG_KEY_CHARS_3: key_regs_reg[3] <= cfg_wdata;
                REG_KEY_LENGTH:  key_length_reg <= cfg_wdata[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign start_ok = !v1_reg && !v2_reg && !m_valid_reg;

    pdd_square_build #(
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_build (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_regs     (key_regs_reg),
        .key_length   (key_length_reg),
        .cfg_clear    (cfg_clear),
        .start_ok     (start_ok),
        .sq_wr        (sq_wr),
        .square_ready (square_ready)
    );

    // whole pipe advances together; the output register is the last stage
    assign en = !m_valid_reg || m_ready;
    assign s_ready = en && square_ready;
    assign accept = s_valid && s_ready;

    assign la = cipher_letter(s_cipher_first);
    assign lb = cipher_letter(s_cipher_second);

    // letter position memory: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (sq_wr.we) begin
            pos_mem[sq_wr.letter] <= sq_wr.pos;
        end
        if (en) begin
            pos_a_reg <= pos_mem[la.idx];
            pos_b_reg <= pos_mem[lb.idx];
        end
    end

    assign r1 = pos_a_reg[5:3];
    assign c1 = pos_a_reg[2:0];
    assign r2 = pos_b_reg[5:3];
    assign c2 = pos_b_reg[2:0];

    always_comb begin
        priority if (r1 == r2) begin
            cell_a = cell_of(r1, ring_prev(c1));
            cell_b = cell_of(r2, ring_prev(c2));
        end else if (c1 == c2) begin
            cell_a = cell_of(ring_prev(r1), c1);
            cell_b = cell_of(ring_prev(r2), c2);
        end else begin
            cell_a = cell_of(r1, c2);
            cell_b = cell_of(r2, c1);
        end
    end

    // key square memory: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (sq_wr.we) begin
            sq_mem[sq_wr.cell_idx] <= sq_wr.letter;
        end
        if (en) begin
            sq_a_reg <= sq_mem[cell_a];
            sq_b_reg <= sq_mem[cell_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv1_reg <= !(la.ok && lb.ok);
            inv2_reg <= inv1_reg;
            invalid_reg <= inv2_reg;
            plain_first_reg <= inv2_reg ? 7'd0 : 7'({2'b00, sq_a_reg} + ASCII_A);
            plain_second_reg <= inv2_reg ? 7'd0 : 7'({2'b00, sq_b_reg} + ASCII_A);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_plain_first = plain_first_reg;
    assign m_plain_second = plain_second_reg;
    assign m_invalid_letter = invalid_reg;

endmodule
`default_nettype wire

### design/pdd_square_build.sv
// key square build sequencer: walks the key bytes, then the alphabet,
// and emits one square/position write per placed letter; uses pdd_pkg
`default_nettype none
module pdd_square_build #(
    parameter int MAX_KEY_BYTES = 28
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pdd_pkg::key_regs_t            key_regs,
    input  wire logic [pdd_pkg::KEY_LEN_W-1:0] key_length,
    input  wire logic                          cfg_clear,
    input  wire logic                          start_ok,
    output pdd_pkg::sq_wr_t                    sq_wr,
    output logic                               square_ready
);
    import pdd_pkg::*;

    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_KEY  = 3'b010,
        ST_FILL = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic ready_reg, ready_next;
    logic [LETTERS-1:0] used_reg, used_next;
    logic [4:0] count_reg, count_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;
    logic [LEN_W-1:0] key_idx_reg, key_idx_next;
    logic [4:0] letter_idx_reg, letter_idx_next;

    logic [7:0] key_byte [MAX_KEY_BYTES];
    logic [LEN_W-1:0] eff_len;
    letter_t kl;
    logic place;
    logic [4:0] place_letter;

    for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_byte
        assign key_byte[i] = key_regs[i / KEY_BYTES_PER_REG][(i % KEY_BYTES_PER_REG) * 8 +: 8];
    end

    assign eff_len = (key_length > KEY_LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                              : key_length[LEN_W-1:0];
    assign kl = key_letter(key_byte[key_idx_reg[KIDX_W-1:0]]);

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        used_next = used_reg;
        count_next = count_reg;
        row_next = row_reg;
        col_next = col_reg;
        key_idx_next = key_idx_reg;
        letter_idx_next = letter_idx_reg;
        place = 1'b0;
        place_letter = letter_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!ready_reg && start_ok) begin
                    used_next = USED_INIT;
                    count_next = '0;
                    row_next = '0;
                    col_next = '0;
                    key_idx_next = '0;
                    letter_idx_next = '0;
                    state_next = (eff_len == '0) ? ST_FILL : ST_KEY;
                end
            end
            ST_KEY: begin
                place = kl.ok && !used_reg[kl.idx];
                place_letter = kl.idx;
                key_idx_next = LEN_W'(key_idx_reg + 1'b1);
                if (key_idx_next == eff_len) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                place = !used_reg[letter_idx_reg];
                letter_idx_next = 5'(letter_idx_reg + 5'd1);
                if (letter_idx_reg == LETTER_LAST) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (place) begin
            used_next[place_letter] = 1'b1;
            if (count_reg < CELL_COUNT) begin
                count_next = 5'(count_reg + 5'd1);
                if (col_reg == SIDE_LAST) begin
                    col_next = '0;
                    row_next = 3'(row_reg + 3'd1);
                end else begin
                    col_next = 3'(col_reg + 3'd1);
                end
            end
        end

        // a key write aborts any build in flight
        if (cfg_clear) begin
            state_next = ST_IDLE;
            ready_next = 1'b0;
        end
    end

    always_comb begin
        sq_wr.we = place && (count_reg < CELL_COUNT) && !cfg_clear;
        sq_wr.cell_idx = count_reg;
        sq_wr.letter = place_letter;
        sq_wr.pos = {row_reg, col_reg};
    end

    assign square_ready = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
        used_reg <= used_next;
        count_reg <= count_next;
        row_reg <= row_next;
        col_reg <= col_next;
        key_idx_reg <= key_idx_next;
        letter_idx_reg <= letter_idx_next;
    end

endmodule
`default_nettype wire

### design/pdd_checker.sv
// port-level checker for the playfair digraph decrypt core, bound to the top
// depends on pdd_pkg and playfair_digraph_decrypt_core_defines.svh
`default_nettype none
`include "playfair_digraph_decrypt_core_defines.svh"
module pdd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_we,
    input wire logic [2:0] cfg_index,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [6:0] m_plain_first,
    input wire logic [6:0] m_plain_second,
    input wire logic       m_invalid_letter
);
    import pdd_pkg::*;

    // a rejected pair never carries letters
    `PDD_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid && m_invalid_letter,
        m_plain_first == 7'd0 && m_plain_second == 7'd0)

    // a decrypted letter is in A-Z and never J
    `PDD_ASSERT_IMP(a_letter_range, aclk, aresetn, m_valid && !m_invalid_letter,
        m_plain_first >= 7'h41 && m_plain_first <= 7'h5a && m_plain_first != 7'h4a &&
        m_plain_second >= 7'h41 && m_plain_second <= 7'h5a && m_plain_second != 7'h4a)

    // a key write forces a rebuild before the next beat
    `PDD_ASSERT_NEXT(a_cfg_blocks, aclk, aresetn,
        cfg_we && cfg_index <= REG_KEY_LENGTH, !s_ready)

    // a stalled result beat holds
    `PDD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_plain_first) && $stable(m_plain_second) &&
        $stable(m_invalid_letter))

endmodule

bind playfair_digraph_decrypt_core pdd_checker u_pdd_checker (.*);
`default_nettype wire
